/* rtl/core/ttyld_pkg.sv */
package ttyld_pkg;

    localparam int LINE_MAX = 256;
    localparam int ADDR_W = $clog2(LINE_MAX);
    localparam int LEN_W = ADDR_W + 1;

    // Result slots: at most three results per request, plus one spare so that
    // the two-bit slot index addresses the whole array.
    localparam int SLOT_N = 4;

    localparam logic [1:0] ACT_KEY = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [2:0] KIND_ECHO = 3'd0;
    localparam logic [2:0] KIND_RAW = 3'd1;
    localparam logic [2:0] KIND_SIGNAL = 3'd2;
    localparam logic [2:0] KIND_LINE = 3'd3;
    localparam logic [2:0] KIND_DATA = 3'd4;
    localparam logic [2:0] KIND_EOF = 3'd5;
    localparam logic [2:0] KIND_EMPTY = 3'd6;

    localparam logic SIG_INTR = 1'b0;
    localparam logic SIG_QUIT = 1'b1;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_INTR = 3'd1;
    localparam logic [2:0] REG_QUIT = 3'd2;
    localparam logic [2:0] REG_ERASE = 3'd3;
    localparam logic [2:0] REG_EOF = 3'd4;

    localparam int MF_SIG = 0;
    localparam int MF_CANON = 1;
    localparam int MF_ECHO = 2;
    localparam int MF_ECHOE = 3;
    localparam int MF_ECHONL = 4;
    localparam int MF_CRMAP = 5;

    localparam logic [5:0] MODE_RESET = 6'd47;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] DEF_INTR = 8'd3;
    localparam logic [7:0] DEF_QUIT = 8'd28;
    localparam logic [7:0] DEF_ERASE = 8'd127;
    localparam logic [7:0] DEF_EOF = 8'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       sig;
    } res_t;

    typedef struct packed {
        logic [5:0] mode;
        logic [7:0] intr;
        logic [7:0] quit;
        logic [7:0] erase;
        logic [7:0] eof_ch;
    } cfg_t;

    typedef struct packed {
        logic              line_we;
        logic [ADDR_W-1:0] line_addr;
        logic [7:0]        wdata;
        logic              queue_re;
        logic [ADDR_W-1:0] queue_addr;
        logic              q_sel;
    } mem_req_t;

    function automatic res_t make_res(logic [2:0] kind, logic [7:0] data, logic sig);
        res_t r;
        r.kind = kind;
        r.data = data;
        r.sig = sig;
        return r;
    endfunction

endpackage

/* rtl/core/ttyld_bank_ram.sv */
module ttyld_bank_ram
    import ttyld_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [LINE_MAX];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ttyld_ctrl.sv */
module ttyld_ctrl
    import ttyld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] key_byte,
    input  cfg_t       cfg,
    output mem_req_t   mem,
    input  logic [7:0] queue_rdata,
    output logic       strobe,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic       signal_code,
    output logic       last
);

    state_t           state_reg, state_next;
    logic [1:0]       act_reg, act_next;
    logic [7:0]       key_reg, key_next;
    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [LEN_W-1:0] q_len_reg, q_len_next;
    logic [LEN_W-1:0] q_pos_reg, q_pos_next;
    logic             eof_reg, eof_next;
    logic             q_sel_reg, q_sel_next;
    res_t             slots_reg [SLOT_N];
    res_t             slots_next [SLOT_N];
    logic [1:0]       n_reg, n_next;
    logic [1:0]       idx_reg, idx_next;
    logic             from_mem_reg, from_mem_next;

    logic [7:0]       c;
    logic [7:0]       c_sig;
    logic [7:0]       vi;
    logic [7:0]       vq;
    logic [7:0]       er;
    logic             canon;
    logic             echo;
    logic [LEN_W-1:0] pos_inc;
    res_t             cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            line_len_reg <= '0;
            q_len_reg <= '0;
            q_pos_reg <= '0;
            eof_reg <= 1'b0;
            q_sel_reg <= 1'b0;
            n_reg <= '0;
            idx_reg <= '0;
            from_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_len_reg <= line_len_next;
            q_len_reg <= q_len_next;
            q_pos_reg <= q_pos_next;
            eof_reg <= eof_next;
            q_sel_reg <= q_sel_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        key_reg <= key_next;
        slots_reg <= slots_next;
    end

    always_comb
    begin
        state_next = state_reg;
        act_next = act_reg;
        key_next = key_reg;
        line_len_next = line_len_reg;
        q_len_next = q_len_reg;
        q_pos_next = q_pos_reg;
        eof_next = eof_reg;
        q_sel_next = q_sel_reg;
        slots_next = slots_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        from_mem_next = from_mem_reg;

        canon = cfg.mode[MF_CANON];
        echo = cfg.mode[MF_ECHO];
        vi = (cfg.intr != CH_NUL) ? cfg.intr : DEF_INTR;
        vq = (cfg.quit != CH_NUL) ? cfg.quit : DEF_QUIT;
        er = (cfg.erase != CH_NUL) ? cfg.erase : DEF_ERASE;
        pos_inc = q_pos_reg + LEN_W'(1);

        // The signal check sees a CR as NL only when CR mapping is on; the
        // line editor afterwards treats every CR as NL in canonical mode.
        c_sig = key_reg;
        if (c_sig == CH_CR && canon && cfg.mode[MF_CRMAP])
        begin
            c_sig = CH_NL;
        end
        c = key_reg;
        if (c == CH_CR && canon)
        begin
            c = CH_NL;
        end

        mem.line_we = 1'b0;
        mem.line_addr = line_len_reg[ADDR_W-1:0];
        mem.wdata = c;
        mem.queue_re = 1'b0;
        mem.queue_addr = q_pos_reg[ADDR_W-1:0];
        mem.q_sel = q_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    key_next = key_byte;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                n_next = 2'd0;
                idx_next = 2'd0;
                from_mem_next = 1'b0;
                for (int i = 0; i < SLOT_N; i++)
                begin
                    slots_next[i] = '0;
                end
                case (act_reg)
                    ACT_KEY:
                    begin
                        if (c == CH_NUL)
                        begin
                            n_next = 2'd0;
                        end
                        else if (cfg.mode[MF_SIG] && c_sig == vi)
                        begin
                            line_len_next = '0;
                            slots_next[0] = make_res(KIND_SIGNAL, 8'd0, SIG_INTR);
                            n_next = 2'd1;
                        end
                        else if (cfg.mode[MF_SIG] && c_sig == vq)
                        begin
                            line_len_next = '0;
                            slots_next[0] = make_res(KIND_SIGNAL, 8'd0, SIG_QUIT);
                            n_next = 2'd1;
                        end
                        else if (canon)
                        begin
                            if (c == CH_BS || c == CH_DEL || c == er)
                            begin
                                if (line_len_reg != '0)
                                begin
                                    line_len_next = line_len_reg - LEN_W'(1);
                                    if (echo && cfg.mode[MF_ECHOE])
                                    begin
                                        slots_next[0] = make_res(KIND_ECHO, CH_BS, 1'b0);
                                        slots_next[1] = make_res(KIND_ECHO, CH_SPACE, 1'b0);
                                        slots_next[2] = make_res(KIND_ECHO, CH_BS, 1'b0);
                                        n_next = 2'd3;
                                    end
                                end
                            end
                            else if (c == CH_NL)
                            begin
                                // Store the NL behind the line, then the line bank
                                // becomes the queue bank.
                                mem.line_we = 1'b1;
                                q_len_next = line_len_reg + LEN_W'(1);
                                q_pos_next = '0;
                                line_len_next = '0;
                                q_sel_next = ~q_sel_reg;
                                if (echo || cfg.mode[MF_ECHONL])
                                begin
                                    slots_next[0] = make_res(KIND_ECHO, CH_NL, 1'b0);
                                    slots_next[1] = make_res(KIND_LINE, 8'd0, 1'b0);
                                    n_next = 2'd2;
                                end
                                else
                                begin
                                    slots_next[0] = make_res(KIND_LINE, 8'd0, 1'b0);
                                    n_next = 2'd1;
                                end
                            end
                            else if (c == cfg.eof_ch || c == DEF_EOF)
                            begin
                                q_pos_next = '0;
                                if (line_len_reg == '0)
                                begin
                                    q_len_next = '0;
                                    eof_next = 1'b1;
                                end
                                else
                                begin
                                    q_len_next = line_len_reg;
                                    line_len_next = '0;
                                    q_sel_next = ~q_sel_reg;
                                end
                                slots_next[0] = make_res(KIND_LINE, 8'd0, 1'b0);
                                n_next = 2'd1;
                            end
                            else if (line_len_reg < LEN_W'(LINE_MAX - 1))
                            begin
                                mem.line_we = 1'b1;
                                line_len_next = line_len_reg + LEN_W'(1);
                                if (echo && (c == CH_TAB || c >= CH_SPACE))
                                begin
                                    slots_next[0] = make_res(KIND_ECHO, c, 1'b0);
                                    n_next = 2'd1;
                                end
                            end
                        end
                        else
                        begin
                            if (echo && c == CH_CR)
                            begin
                                slots_next[0] = make_res(KIND_ECHO,
                                    cfg.mode[MF_CRMAP] ? CH_NL : CH_CR, 1'b0);
                                slots_next[1] = make_res(KIND_RAW, c, 1'b0);
                                n_next = 2'd2;
                            end
                            else if (echo && (c == CH_TAB || c == CH_NL || c == CH_BS
                                              || c >= CH_SPACE))
                            begin
                                slots_next[0] = make_res(KIND_ECHO, c, 1'b0);
                                slots_next[1] = make_res(KIND_RAW, c, 1'b0);
                                n_next = 2'd2;
                            end
                            else
                            begin
                                slots_next[0] = make_res(KIND_RAW, c, 1'b0);
                                n_next = 2'd1;
                            end
                        end
                    end
                    ACT_READ:
                    begin
                        n_next = 2'd1;
                        if (eof_reg && q_pos_reg >= q_len_reg)
                        begin
                            eof_next = 1'b0;
                            q_len_next = '0;
                            q_pos_next = '0;
                            slots_next[0] = make_res(KIND_EOF, 8'd0, 1'b0);
                        end
                        else if (q_pos_reg < q_len_reg)
                        begin
                            // The queue bank returns the byte in the next cycle.
                            mem.queue_re = 1'b1;
                            from_mem_next = 1'b1;
                            slots_next[0] = make_res(KIND_DATA, 8'd0, 1'b0);
                            if (pos_inc >= q_len_reg)
                            begin
                                q_len_next = '0;
                                q_pos_next = '0;
                            end
                            else
                            begin
                                q_pos_next = pos_inc;
                            end
                        end
                        else
                        begin
                            q_len_next = '0;
                            q_pos_next = '0;
                            slots_next[0] = make_res(KIND_EMPTY, 8'd0, 1'b0);
                        end
                    end
                    ACT_FLUSH:
                    begin
                        line_len_next = '0;
                        q_len_next = '0;
                        q_pos_next = '0;
                        eof_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = (n_next == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == n_reg - 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cur = slots_reg[idx_reg];
    assign busy = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);
    assign kind = cur.kind;
    assign data_byte = from_mem_reg ? queue_rdata : cur.data;
    assign signal_code = cur.sig;
    assign last = (idx_reg == n_reg - 2'd1);

endmodule

/* rtl/core/tty_canonical_line_discipline.sv */
// Terminal input line discipline. A request is taken when start is high and
// busy is low; action selects a key byte, a read of one queued byte, or a
// flush. Each request passes through a decode state and then presents its
// results one per cycle on kind, data_byte and signal_code while strobe is
// high, with last marking the final one; the receiver cannot hold them off,
// so they must be captured on the cycle they appear. A request keeps busy
// high through decode and its results (zero to three), and no new request is
// taken until busy falls. The single-port line and queue banks take at most
// one access per request, and the result sequencer emits one result per
// cycle. The two banks swap roles when a line is committed, so no copy takes
// place. Configuration registers are written through wr_en, wr_index and
// wr_data; the user must do so only while busy is low, as the block itself
// does not enforce it.
module tty_canonical_line_discipline
    import ttyld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] key_byte,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    output logic       strobe,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic       signal_code,
    output logic       last
);

    cfg_t       cfg_reg;
    mem_req_t   mem;
    logic [7:0] rdata_a;
    logic [7:0] rdata_b;
    logic [7:0] queue_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_RESET;
            cfg_reg.intr <= DEF_INTR;
            cfg_reg.quit <= DEF_QUIT;
            cfg_reg.erase <= DEF_ERASE;
            cfg_reg.eof_ch <= DEF_EOF;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE:  cfg_reg.mode <= wr_data[5:0];
                REG_INTR:  cfg_reg.intr <= wr_data;
                REG_QUIT:  cfg_reg.quit <= wr_data;
                REG_ERASE: cfg_reg.erase <= wr_data;
                REG_EOF:   cfg_reg.eof_ch <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    ttyld_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key_byte    (key_byte),
        .cfg         (cfg_reg),
        .mem         (mem),
        .queue_rdata (queue_rdata),
        .strobe      (strobe),
        .kind        (kind),
        .data_byte   (data_byte),
        .signal_code (signal_code),
        .last        (last)
    );

    // Bank A holds the queue when q_sel is low, bank B when it is high.
    ttyld_bank_ram u_bank_a (
        .clk   (clk),
        .we    (mem.line_we & mem.q_sel),
        .re    (mem.queue_re & ~mem.q_sel),
        .addr  (mem.q_sel ? mem.line_addr : mem.queue_addr),
        .wdata (mem.wdata),
        .rdata (rdata_a)
    );

    ttyld_bank_ram u_bank_b (
        .clk   (clk),
        .we    (mem.line_we & ~mem.q_sel),
        .re    (mem.queue_re & mem.q_sel),
        .addr  (mem.q_sel ? mem.queue_addr : mem.line_addr),
        .wdata (mem.wdata),
        .rdata (rdata_b)
    );

    assign queue_rdata = mem.q_sel ? rdata_b : rdata_a;

endmodule

/* tb/sv/ttyld_checker.sv */
module ttyld_checker
    import ttyld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] key_byte,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    input  logic       strobe,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       signal_code,
    input  logic       last,
    output int         fail_count,
    output int         results_due
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       sig;
        logic       last;
    } tty_result_t;

    tty_result_t due_results[$];
    tty_result_t batch [3];
    int          batch_n;

    logic [7:0] line_mem [LINE_MAX];
    logic [7:0] queue_mem [LINE_MAX];
    int         line_len;
    int         q_len;
    int         q_pos;
    logic       eof_pend;

    logic [5:0] mode;
    logic [7:0] intr_ch;
    logic [7:0] quit_ch;
    logic [7:0] erase_ch;
    logic [7:0] eof_ch;

    initial
    begin
        fail_count = 0;
        results_due = 0;
    end

    function automatic void emit(logic [2:0] k, logic [7:0] d, logic s);
        batch[batch_n] = '{kind: k, data: d, sig: s, last: 1'b0};
        batch_n++;
    endfunction

    // A committed line replaces whatever is left unread in the queue.
    function automatic void commit_line(logic with_nl);
        int i;
        for (i = 0; i < line_len; i++)
            queue_mem[i] = line_mem[i];
        q_len = line_len;
        if (with_nl && q_len < LINE_MAX)
        begin
            queue_mem[q_len] = CH_NL;
            q_len++;
        end
        q_pos = 0;
        line_len = 0;
    endfunction

    function automatic void cook_key(logic [7:0] key_in);
        logic [7:0] c;
        logic [7:0] vi;
        logic [7:0] vq;
        logic [7:0] er;
        logic       canon;
        logic       echo_on;
        c = key_in;
        canon = mode[MF_CANON];
        echo_on = mode[MF_ECHO];
        if (c == CH_CR && canon && mode[MF_CRMAP])
            c = CH_NL;
        if (c == CH_NUL)
            return;
        if (mode[MF_SIG])
        begin
            vi = (intr_ch != 8'd0) ? intr_ch : DEF_INTR;
            vq = (quit_ch != 8'd0) ? quit_ch : DEF_QUIT;
            if (c == vi)
            begin
                line_len = 0;
                emit(KIND_SIGNAL, 8'd0, SIG_INTR);
                return;
            end
            if (c == vq)
            begin
                line_len = 0;
                emit(KIND_SIGNAL, 8'd0, SIG_QUIT);
                return;
            end
        end
        if (canon)
        begin
            er = (erase_ch != 8'd0) ? erase_ch : DEF_ERASE;
            if (c == CH_CR)
                c = CH_NL;
            if (c == CH_BS || c == CH_DEL || c == er)
            begin
                if (line_len > 0)
                begin
                    line_len--;
                    if (echo_on && mode[MF_ECHOE])
                    begin
                        emit(KIND_ECHO, CH_BS, 1'b0);
                        emit(KIND_ECHO, CH_SPACE, 1'b0);
                        emit(KIND_ECHO, CH_BS, 1'b0);
                    end
                end
                return;
            end
            if (c == CH_NL)
            begin
                if (echo_on || mode[MF_ECHONL])
                    emit(KIND_ECHO, CH_NL, 1'b0);
                commit_line(1'b1);
                emit(KIND_LINE, 8'd0, 1'b0);
                return;
            end
            if (c == eof_ch || c == CH_EOT)
            begin
                q_len = 0;
                q_pos = 0;
                if (line_len == 0)
                    eof_pend = 1'b1;
                else
                    commit_line(1'b0);
                emit(KIND_LINE, 8'd0, 1'b0);
                return;
            end
            // The last slot stays free so that a full line still gets its NL.
            if (line_len + 1 >= LINE_MAX)
                return;
            line_mem[line_len] = c;
            line_len++;
            if (echo_on && (c == CH_TAB || c >= CH_SPACE))
                emit(KIND_ECHO, c, 1'b0);
            return;
        end
        if (echo_on)
        begin
            if (c == CH_CR)
                emit(KIND_ECHO, mode[MF_CRMAP] ? CH_NL : CH_CR, 1'b0);
            else if (c == CH_TAB || c == CH_NL || c >= CH_SPACE || c == CH_BS)
                emit(KIND_ECHO, c, 1'b0);
        end
        emit(KIND_RAW, c, 1'b0);
    endfunction

    function automatic void read_one();
        logic [7:0] b;
        if (eof_pend && q_pos >= q_len)
        begin
            eof_pend = 1'b0;
            q_len = 0;
            q_pos = 0;
            emit(KIND_EOF, 8'd0, 1'b0);
        end
        else if (q_pos < q_len)
        begin
            b = queue_mem[q_pos];
            q_pos++;
            if (q_pos >= q_len)
            begin
                q_len = 0;
                q_pos = 0;
            end
            emit(KIND_DATA, b, 1'b0);
        end
        else
        begin
            q_len = 0;
            q_pos = 0;
            emit(KIND_EMPTY, 8'd0, 1'b0);
        end
    endfunction

    function automatic void predict_request(logic [1:0] act, logic [7:0] key);
        int i;
        batch_n = 0;
        case (act)
            ACT_KEY: cook_key(key);
            ACT_READ: read_one();
            ACT_FLUSH:
            begin
                line_len = 0;
                q_len = 0;
                q_pos = 0;
                eof_pend = 1'b0;
            end
            default: ;
        endcase
        for (i = 0; i < batch_n; i++)
        begin
            if (i == batch_n - 1)
                batch[i].last = 1'b1;
            due_results.push_back(batch[i]);
        end
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [7:0] value);
        case (idx)
            REG_MODE: mode = value[5:0];
            REG_INTR: intr_ch = value;
            REG_QUIT: quit_ch = value;
            REG_ERASE: erase_ch = value;
            REG_EOF: eof_ch = value;
            default: ;
        endcase
    endfunction

    function automatic void check_result();
        tty_result_t want;
        if (due_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: kind %0d data %02h sig %0d last %0d",
                         kind, data_byte, signal_code, last);
            return;
        end
        want = due_results.pop_front();
        if (kind !== want.kind || data_byte !== want.data ||
            signal_code !== want.sig || last !== want.last)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result mismatch: expected kind %0d data %02h sig %0d last %0d, got kind %0d data %02h sig %0d last %0d",
                         want.kind, want.data, want.sig, want.last,
                         kind, data_byte, signal_code, last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len = 0;
            q_len = 0;
            q_pos = 0;
            eof_pend = 1'b0;
            mode = MODE_RESET;
            intr_ch = DEF_INTR;
            quit_ch = DEF_QUIT;
            erase_ch = DEF_ERASE;
            eof_ch = DEF_EOF;
            due_results.delete();
        end
        else
        begin
            if (strobe)
                check_result();
            if (wr_en)
                write_reg(wr_index, wr_data);
            if (start && !busy)
                predict_request(action, key_byte);
        end
        results_due = due_results.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;
    import ttyld_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 330;
    localparam int PHASE_ITEMS = 8;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] action;
    logic [7:0] key_byte;
    logic       wr_en;
    logic [2:0] wr_index;
    logic [7:0] wr_data;
    logic       strobe;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       signal_code;
    logic       last;
    int         fail_count;
    int         results_due;

    // Stimulus-side copy of the characters in force, so special keys get hit.
    logic [5:0] stim_mode;
    logic [7:0] stim_intr;
    logic [7:0] stim_quit;
    logic [7:0] stim_erase;
    logic [7:0] stim_eof;
    bit         burst;
    int         sent_items;
    int         phase;
    int         phase_end;
    int         k;

    tty_canonical_line_discipline i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .key_byte(key_byte),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .strobe(strobe),
        .kind(kind),
        .data_byte(data_byte),
        .signal_code(signal_code),
        .last(last)
    );

    ttyld_checker i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .key_byte(key_byte),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .strobe(strobe),
        .kind(kind),
        .data_byte(data_byte),
        .signal_code(signal_code),
        .last(last),
        .fail_count(fail_count),
        .results_due(results_due)
    );

    always #10 clk = ~clk;

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(32, 126));
        if (r < 65)
            return 8'($urandom_range(0, 31));
        if (r < 75)
            return 8'($urandom_range(128, 255));
        case ($urandom_range(0, 9))
            0: return stim_intr;
            1: return stim_quit;
            2: return stim_erase;
            3: return stim_eof;
            4: return CH_EOT;
            5: return CH_BS;
            6: return CH_DEL;
            7: return CH_CR;
            8: return CH_NL;
            default: return CH_NUL;
        endcase
    endfunction

    // Drive one request at the falling edge and hold it until it is taken.
    task automatic issue(input logic [1:0] act, input logic [7:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        action = act;
        key_byte = key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (act != ACT_UNUSED && !(act == ACT_KEY && key == CH_NUL))
            sent_items++;
    endtask

    task automatic wait_idle();
        start = 1'b0;
        @(negedge clk);
        while (results_due != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = value;
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic configure(input int p);
        logic [7:0] c [4];
        int i;
        case (p)
            0:
            begin
                stim_mode = 6'h3F;
                for (i = 0; i < 4; i++)
                    c[i] = 8'h00;
            end
            1:
            begin
                stim_mode = 6'h00;
                for (i = 0; i < 4; i++)
                    c[i] = 8'hFF;
            end
            2:
            begin
                stim_mode = 6'h25;
                c[0] = DEF_INTR;
                c[1] = DEF_QUIT;
                c[2] = DEF_ERASE;
                c[3] = DEF_EOF;
            end
            3:
            begin
                stim_mode = 6'h12;
                for (i = 0; i < 4; i++)
                    c[i] = 8'($urandom_range(33, 126));
            end
            4:
            begin
                stim_mode = MODE_RESET;
                c[0] = DEF_INTR;
                c[1] = DEF_QUIT;
                c[2] = DEF_ERASE;
                c[3] = DEF_EOF;
            end
            default:
            begin
                stim_mode = 6'($urandom_range(0, 63));
                for (i = 0; i < 4; i++)
                    c[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom())
                                                        : 8'($urandom_range(1, 31));
            end
        endcase
        stim_intr = c[0];
        stim_quit = c[1];
        stim_erase = c[2];
        stim_eof = c[3];
        // The upper bits of the mode write are don't-care and get random values.
        write_reg(REG_MODE, {2'($urandom_range(0, 3)), stim_mode});
        write_reg(REG_INTR, stim_intr);
        write_reg(REG_QUIT, stim_quit);
        write_reg(REG_ERASE, stim_erase);
        write_reg(REG_EOF, stim_eof);
    endtask

    task automatic directed();
        issue(ACT_READ, 8'h00);
        issue(ACT_KEY, CH_NUL);
        issue(ACT_KEY, CH_DEL);
        issue(ACT_KEY, 8'h61);
        issue(ACT_KEY, CH_TAB);
        issue(ACT_KEY, 8'h01);
        issue(ACT_KEY, 8'hFF);
        issue(ACT_KEY, CH_BS);
        issue(ACT_KEY, CH_CR);
        repeat (5) issue(ACT_READ, 8'hFF);
        issue(ACT_KEY, 8'h78);
        issue(ACT_KEY, DEF_INTR);
        issue(ACT_KEY, DEF_QUIT);
        issue(ACT_KEY, 8'h7A);
        issue(ACT_KEY, DEF_EOF);
        issue(ACT_KEY, DEF_EOF);
        repeat (3) issue(ACT_READ, 8'h00);
        issue(ACT_KEY, CH_SPACE);
        issue(ACT_FLUSH, 8'hFF);
        issue(ACT_UNUSED, 8'h55);
        issue(ACT_READ, 8'hAA);
    endtask

    // Type past the line limit, commit, read a few bytes back and flush the rest.
    task automatic fill_line();
        burst = 1'b1;
        repeat (LINE_MAX + 2) issue(ACT_KEY, 8'($urandom_range(32, 126)));
        issue(ACT_KEY, CH_NL);
        burst = 1'b0;
        repeat (4) issue(ACT_READ, 8'($urandom()));
        issue(ACT_FLUSH, 8'h00);
    endtask

    task automatic type_line();
        int len;
        int r;
        int i;
        len = $urandom_range(0, 12);
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                issue(ACT_KEY, 8'($urandom_range(32, 126)));
            else if (r < 82)
            begin
                case ($urandom_range(0, 2))
                    0: issue(ACT_KEY, CH_BS);
                    1: issue(ACT_KEY, CH_DEL);
                    default: issue(ACT_KEY, stim_erase);
                endcase
            end
            else
                issue(ACT_KEY, pick_key());
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            issue(ACT_KEY, CH_NL);
        else if (r < 65)
            issue(ACT_KEY, CH_CR);
        else if (r < 80)
            issue(ACT_KEY, stim_eof);
        else if (r < 90)
            issue(ACT_KEY, CH_EOT);
        else
            issue(ACT_KEY, pick_key());
        repeat ($urandom_range(0, len + 3)) issue(ACT_READ, 8'($urandom()));
    endtask

    task automatic run_sequence();
        int r;
        burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (stim_mode[MF_CANON] && r < 70)
            type_line();
        else if (r < 85)
            repeat ($urandom_range(1, 6)) issue(ACT_KEY, pick_key());
        else if (r < 93)
            repeat ($urandom_range(1, 4)) issue(ACT_READ, 8'($urandom()));
        else
            repeat ($urandom_range(1, 3)) issue(2'($urandom_range(0, 3)), 8'($urandom()));
        burst = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_KEY;
        key_byte = 8'h00;
        wr_en = 1'b0;
        wr_index = REG_MODE;
        wr_data = 8'h00;
        burst = 1'b0;
        sent_items = 0;
        stim_mode = MODE_RESET;
        stim_intr = DEF_INTR;
        stim_quit = DEF_QUIT;
        stim_erase = DEF_ERASE;
        stim_eof = DEF_EOF;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        wait_idle();
        directed();
        wait_idle();
        fill_line();
        phase = 0;
        while (sent_items < TOTAL_ITEMS)
        begin
            wait_idle();
            configure(phase);
            phase_end = sent_items + PHASE_ITEMS;
            k = 0;
            while (sent_items < phase_end && sent_items < TOTAL_ITEMS && k < 200)
            begin
                run_sequence();
                k++;
            end
            phase++;
        end
        wait_idle();
        if (fail_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* tty_canonical_line_discipline.f */
rtl/core/ttyld_pkg.sv
rtl/core/ttyld_bank_ram.sv
rtl/core/ttyld_ctrl.sv
rtl/core/tty_canonical_line_discipline.sv
tb/sv/ttyld_checker.sv
tb/sv/tb.sv
